// File: hdl/cps_pkg.sv
package cps_pkg;

    localparam int RADIUS_W = 31;
    localparam int MASS_W   = 31;
    localparam int RSUM_W   = RADIUS_W + 1;
    localparam int TOTAL_W  = MASS_W + 1;
    localparam int STATUS_W = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [STATUS_W-1:0] {
        STATUS_MOVED      = 2'd0,
        STATUS_COINCIDENT = 2'd1,
        STATUS_NO_MASS    = 2'd2
    } status_t;

endpackage

// File: hdl/cps_if.sv
interface cps_in_if #(parameter int W = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [W-1:0]           a_x;
    logic signed [W-1:0]           a_y;
    logic signed [W-1:0]           b_x;
    logic signed [W-1:0]           b_y;
    logic [cps_pkg::RADIUS_W-1:0]  a_radius;
    logic [cps_pkg::RADIUS_W-1:0]  b_radius;
    logic [cps_pkg::MASS_W-1:0]    a_mass;
    logic [cps_pkg::MASS_W-1:0]    b_mass;

    modport source (
        output valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_mass, b_mass,
        input  ready
    );
    modport sink (
        input  valid, a_x, a_y, b_x, b_y, a_radius, b_radius, a_mass, b_mass,
        output ready
    );
endinterface

interface cps_out_if #(parameter int W = 32) ();
    logic                          valid;
    logic                          ready;
    logic signed [W-1:0]           new_a_x;
    logic signed [W-1:0]           new_a_y;
    logic signed [W-1:0]           new_b_x;
    logic signed [W-1:0]           new_b_y;
    logic [cps_pkg::STATUS_W-1:0]  status;

    modport source (
        output valid, new_a_x, new_a_y, new_b_x, new_b_y, status,
        input  ready
    );
    modport sink (
        input  valid, new_a_x, new_a_y, new_b_x, new_b_y, status,
        output ready
    );
endinterface

// File: hdl/cps_front.sv
module cps_front #(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    cps_in_if.sink           req,
    input  logic             queue_full,
    output logic             push,
    output logic [7*W+100:0] push_data
);

    localparam int DW = W + 1;
    localparam int SW = 2 * W + 2;
    localparam int NS = DW + 3;

    typedef struct packed {
        logic [W-1:0]                 a_x;
        logic [W-1:0]                 a_y;
        logic [W-1:0]                 b_x;
        logic [W-1:0]                 b_y;
        logic [W:0]                   ux;
        logic [W:0]                   uy;
        logic                         sx_pos;
        logic                         sy_pos;
        logic [W:0]                   span;
        logic [cps_pkg::RSUM_W-1:0]   rsum;
        logic [cps_pkg::MASS_W-1:0]   a_mass;
        logic [cps_pkg::MASS_W-1:0]   b_mass;
        cps_pkg::status_t             status;
    } item_t;

    typedef struct packed {
        item_t          item;
        logic [SW-1:0]  sum;
        logic [DW+1:0]  rem;
        logic [DW-1:0]  root;
    } root_st_t;

    logic [NS-1:0]  vld_reg;
    item_t          f0_reg;
    item_t          f0_next;
    item_t          f1_reg;
    logic [SW-1:0]  sqx_reg;
    logic [SW-1:0]  sqy_reg;
    root_st_t       f2_reg;
    root_st_t       rt_reg  [DW];
    root_st_t       rt_next [DW];
    logic [W:0]     dx;
    logic [W:0]     dy;
    logic           adv;

    assign adv       = !vld_reg[NS-1] || !queue_full;
    assign req.ready = adv;
    assign push      = vld_reg[NS-1] && !queue_full;

    always_comb
    begin
        dx = {req.a_x[W-1], req.a_x} - {req.b_x[W-1], req.b_x};
        dy = {req.a_y[W-1], req.a_y} - {req.b_y[W-1], req.b_y};
        f0_next.a_x    = req.a_x;
        f0_next.a_y    = req.a_y;
        f0_next.b_x    = req.b_x;
        f0_next.b_y    = req.b_y;
        f0_next.ux     = dx[W] ? (W+1)'(~dx + 1'b1) : dx;
        f0_next.uy     = dy[W] ? (W+1)'(~dy + 1'b1) : dy;
        f0_next.sx_pos = !dx[W] && (dx != '0);
        f0_next.sy_pos = !dy[W] && (dy != '0);
        f0_next.span   = '0;
        f0_next.rsum   = {1'b0, req.a_radius} + {1'b0, req.b_radius};
        f0_next.a_mass = req.a_mass;
        f0_next.b_mass = req.b_mass;
        if (dx == '0 && dy == '0)
        begin
            f0_next.status = cps_pkg::STATUS_COINCIDENT;
        end
        else if (req.a_mass == '0 && req.b_mass == '0)
        begin
            f0_next.status = cps_pkg::STATUS_NO_MASS;
        end
        else
        begin
            f0_next.status = cps_pkg::STATUS_MOVED;
        end
    end

    // one result bit per stage, two radicand bits brought down each time
    always_comb
    begin
        root_st_t       src;
        logic [DW+1:0]  shifted;
        logic [DW+1:0]  trial;
        for (int k = 0; k < DW; k++)
        begin
            src     = (k == 0) ? f2_reg : rt_reg[(k == 0) ? 0 : k - 1];
            shifted = {src.rem[DW-1:0], src.sum[2*(DW-1-k) +: 2]};
            trial   = {src.root, 2'b01};
            rt_next[k] = src;
            if (shifted >= trial)
            begin
                rt_next[k].rem  = shifted - trial;
                rt_next[k].root = {src.root[DW-2:0], 1'b1};
            end
            else
            begin
                rt_next[k].rem  = shifted;
                rt_next[k].root = {src.root[DW-2:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        item_t last;
        last      = rt_reg[DW-1].item;
        last.span = rt_reg[DW-1].root;
        push_data = last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NS-2:0], req.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f0_reg      <= f0_next;
            f1_reg      <= f0_reg;
            sqx_reg     <= SW'(f0_reg.ux) * SW'(f0_reg.ux);
            sqy_reg     <= SW'(f0_reg.uy) * SW'(f0_reg.uy);
            f2_reg.item <= f1_reg;
            f2_reg.sum  <= sqx_reg + sqy_reg;
            f2_reg.rem  <= '0;
            f2_reg.root <= '0;
            for (int k = 0; k < DW; k++)
            begin
                rt_reg[k] <= rt_next[k];
            end
        end
    end

endmodule

// File: hdl/cps_queue.sv
module cps_queue #(
    parameter int DATA_W = 325
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              empty
);

    logic [DATA_W-1:0]               mem [cps_pkg::QUEUE_DEPTH];
    logic [cps_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [cps_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [cps_pkg::QUEUE_CNT_W-1:0] count_reg;

    assign full     = count_reg == cps_pkg::QUEUE_CNT_W'(cps_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hdl/cps_back.sv
module cps_back #(
    parameter int W = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  logic [7*W+100:0] pop_data,
    output logic             pop,
    cps_out_if.source        rsp
);

    localparam int MAGW = (W + 1 > 32) ? W + 1 : 32;
    localparam int QW   = MAGW;
    localparam int NW   = MAGW + cps_pkg::MASS_W;
    localparam int PW   = W + 1 + MAGW;
    localparam int EW   = ((W > MAGW) ? W : MAGW) + 2;
    localparam int NB   = 2 * QW + 4;
    localparam logic signed [EW-1:0] SAT_HI = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] SAT_LO = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};

    typedef struct packed {
        logic [W-1:0]                 a_x;
        logic [W-1:0]                 a_y;
        logic [W-1:0]                 b_x;
        logic [W-1:0]                 b_y;
        logic [W:0]                   ux;
        logic [W:0]                   uy;
        logic                         sx_pos;
        logic                         sy_pos;
        logic [W:0]                   span;
        logic [cps_pkg::RSUM_W-1:0]   rsum;
        logic [cps_pkg::MASS_W-1:0]   a_mass;
        logic [cps_pkg::MASS_W-1:0]   b_mass;
        cps_pkg::status_t             status;
    } item_t;

    typedef struct packed {
        logic [W-1:0]     a_x;
        logic [W-1:0]     a_y;
        logic [W-1:0]     b_x;
        logic [W-1:0]     b_y;
        logic [W:0]       ux;
        logic [W:0]       uy;
        logic             sx_pos;
        logic             sy_pos;
        logic             neg;
        logic [W:0]       span;
        cps_pkg::status_t status;
    } carry_t;

    typedef struct packed {
        carry_t                        cr;
        logic [MAGW-1:0]               mag;
        logic [cps_pkg::MASS_W-1:0]    a_mass;
        logic [cps_pkg::MASS_W-1:0]    b_mass;
        logic [cps_pkg::TOTAL_W-1:0]   total;
    } b0_t;

    typedef struct packed {
        carry_t                        cr;
        logic [cps_pkg::TOTAL_W-1:0]   total;
        logic [NW-1:0]                 rem_a;
        logic [NW-1:0]                 rem_b;
        logic [QW-1:0]                 q_a;
        logic [QW-1:0]                 q_b;
    } d1_t;

    typedef struct packed {
        carry_t               cr;
        logic [W+1:0]         den;
        logic [3:0][PW-1:0]   rem;
        logic [3:0][QW-1:0]   q;
    } d2_t;

    typedef struct packed {
        logic [W-1:0]     new_a_x;
        logic [W-1:0]     new_a_y;
        logic [W-1:0]     new_b_x;
        logic [W-1:0]     new_b_y;
        cps_pkg::status_t status;
    } out_t;

    item_t          qi;
    logic [NB-1:0]  vld_reg;
    b0_t            b0_reg;
    b0_t            b0_next;
    d1_t            b1_reg;
    d1_t            d1_reg  [QW];
    d1_t            d1_next [QW];
    d2_t            m2_reg;
    d2_t            d2_reg  [QW];
    d2_t            d2_next [QW];
    out_t           out_reg;
    out_t           out_next;
    logic           adv;

    assign qi  = pop_data;
    assign adv = !vld_reg[NB-1] || rsp.ready;
    assign pop = adv && !empty;

    assign rsp.valid   = vld_reg[NB-1];
    assign rsp.new_a_x = out_reg.new_a_x;
    assign rsp.new_a_y = out_reg.new_a_y;
    assign rsp.new_b_x = out_reg.new_b_x;
    assign rsp.new_b_y = out_reg.new_b_y;
    assign rsp.status  = out_reg.status;

    function automatic logic [W-1:0] move(input logic [W-1:0] base,
                                          input logic [QW-1:0] q,
                                          input logic plus);
        logic signed [EW-1:0] b;
        logic signed [EW-1:0] m;
        logic signed [EW-1:0] s;
        b = EW'(signed'(base));
        m = EW'(q);
        s = plus ? b + m : b - m;
        if (s > SAT_HI)
        begin
            s = SAT_HI;
        end
        else if (s < SAT_LO)
        begin
            s = SAT_LO;
        end
        return s[W-1:0];
    endfunction

    always_comb
    begin
        logic [MAGW:0] r;
        r = {1'b0, MAGW'(qi.rsum)} - {1'b0, MAGW'(qi.span)};
        b0_next.cr.a_x    = qi.a_x;
        b0_next.cr.a_y    = qi.a_y;
        b0_next.cr.b_x    = qi.b_x;
        b0_next.cr.b_y    = qi.b_y;
        b0_next.cr.ux     = qi.ux;
        b0_next.cr.uy     = qi.uy;
        b0_next.cr.sx_pos = qi.sx_pos;
        b0_next.cr.sy_pos = qi.sy_pos;
        b0_next.cr.neg    = r[MAGW];
        b0_next.cr.span   = qi.span;
        b0_next.cr.status = qi.status;
        b0_next.mag       = r[MAGW] ? MAGW'(~r + 1'b1) : r[MAGW-1:0];
        b0_next.a_mass    = qi.a_mass;
        b0_next.b_mass    = qi.b_mass;
        b0_next.total     = {1'b0, qi.a_mass} + {1'b0, qi.b_mass};
    end

    // mass shares: restoring division, one quotient bit per stage
    always_comb
    begin
        d1_t            src;
        logic [NW-1:0]  dsh;
        for (int k = 0; k < QW; k++)
        begin
            src = (k == 0) ? b1_reg : d1_reg[(k == 0) ? 0 : k - 1];
            dsh = NW'(src.total) << (QW - 1 - k);
            d1_next[k] = src;
            if (src.rem_a >= dsh)
            begin
                d1_next[k].rem_a = src.rem_a - dsh;
                d1_next[k].q_a   = {src.q_a[QW-2:0], 1'b1};
            end
            else
            begin
                d1_next[k].q_a   = {src.q_a[QW-2:0], 1'b0};
            end
            if (src.rem_b >= dsh)
            begin
                d1_next[k].rem_b = src.rem_b - dsh;
                d1_next[k].q_b   = {src.q_b[QW-2:0], 1'b1};
            end
            else
            begin
                d1_next[k].q_b   = {src.q_b[QW-2:0], 1'b0};
            end
        end
    end

    // move components: four lanes divided by twice the distance
    always_comb
    begin
        d2_t            src;
        logic [PW-1:0]  dsh;
        for (int k = 0; k < QW; k++)
        begin
            src = (k == 0) ? m2_reg : d2_reg[(k == 0) ? 0 : k - 1];
            dsh = PW'(src.den) << (QW - 1 - k);
            d2_next[k] = src;
            for (int l = 0; l < 4; l++)
            begin
                if (src.rem[l] >= dsh)
                begin
                    d2_next[k].rem[l] = src.rem[l] - dsh;
                    d2_next[k].q[l]   = {src.q[l][QW-2:0], 1'b1};
                end
                else
                begin
                    d2_next[k].q[l]   = {src.q[l][QW-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        d2_t    s;
        logic   px;
        logic   py;
        s  = d2_reg[QW-1];
        px = s.cr.sx_pos != s.cr.neg;
        py = s.cr.sy_pos != s.cr.neg;
        out_next.status = s.cr.status;
        if (s.cr.status == cps_pkg::STATUS_MOVED)
        begin
            out_next.new_a_x = move(s.cr.a_x, s.q[0], px);
            out_next.new_a_y = move(s.cr.a_y, s.q[1], py);
            out_next.new_b_x = move(s.cr.b_x, s.q[2], !px);
            out_next.new_b_y = move(s.cr.b_y, s.q[3], !py);
        end
        else
        begin
            out_next.new_a_x = s.cr.a_x;
            out_next.new_a_y = s.cr.a_y;
            out_next.new_b_x = s.cr.b_x;
            out_next.new_b_y = s.cr.b_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NB-2:0], !empty};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b0_reg       <= b0_next;
            b1_reg.cr    <= b0_reg.cr;
            b1_reg.total <= b0_reg.total;
            b1_reg.rem_a <= NW'(b0_reg.mag) * NW'(b0_reg.b_mass);
            b1_reg.rem_b <= NW'(b0_reg.mag) * NW'(b0_reg.a_mass);
            b1_reg.q_a   <= '0;
            b1_reg.q_b   <= '0;
            for (int k = 0; k < QW; k++)
            begin
                d1_reg[k] <= d1_next[k];
                d2_reg[k] <= d2_next[k];
            end
            m2_reg.cr     <= d1_reg[QW-1].cr;
            m2_reg.den    <= {d1_reg[QW-1].cr.span, 1'b0};
            m2_reg.rem[0] <= PW'(d1_reg[QW-1].cr.ux) * PW'(d1_reg[QW-1].q_a);
            m2_reg.rem[1] <= PW'(d1_reg[QW-1].cr.uy) * PW'(d1_reg[QW-1].q_a);
            m2_reg.rem[2] <= PW'(d1_reg[QW-1].cr.ux) * PW'(d1_reg[QW-1].q_b);
            m2_reg.rem[3] <= PW'(d1_reg[QW-1].cr.uy) * PW'(d1_reg[QW-1].q_b);
            m2_reg.q      <= '0;
            out_reg       <= out_next;
        end
    end

endmodule

// File: hdl/circle_pair_separation_unit.sv
// Throughput: one pair per cycle while rsp.ready holds; the square root and both
// dividers are fully pipelined, one result bit per stage, with a four-entry queue
// between front and back.
// Reset: rst_n clears valid bits and queue pointers asynchronously; the
// datapath registers are not reset. No clearing pass.
module circle_pair_separation_unit #(
    parameter int COORD_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    cps_in_if.sink     req,
    cps_out_if.source  rsp
);

    localparam int QDW = 7 * COORD_WIDTH + 101;

    logic            push;
    logic [QDW-1:0]  push_data;
    logic            full;
    logic            pop;
    logic [QDW-1:0]  pop_data;
    logic            empty;

    cps_front #(.W(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .queue_full (full),
        .push       (push),
        .push_data  (push_data)
    );

    cps_queue #(.DATA_W(QDW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    cps_back #(.W(COORD_WIDTH)) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop_data (pop_data),
        .pop      (pop),
        .rsp      (rsp)
    );

endmodule

// File: hdl/cps_checker.sv
module cps_checker #(
    parameter int W = 32
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [W-1:0]                  new_a_x,
    input logic [W-1:0]                  new_a_y,
    input logic [W-1:0]                  new_b_x,
    input logic [W-1:0]                  new_b_y,
    input logic [cps_pkg::STATUS_W-1:0]  status
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable({new_a_x, new_a_y, new_b_x, new_b_y, status}))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> status == cps_pkg::STATUS_MOVED || status == cps_pkg::STATUS_COINCIDENT
                      || status == cps_pkg::STATUS_NO_MASS)
        else $error("bad status code");

    a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == cps_pkg::STATUS_COINCIDENT
            |-> new_a_x == new_b_x && new_a_y == new_b_y)
        else $error("coincident result with distinct centres");

endmodule

bind circle_pair_separation_unit cps_checker #(.W(COORD_WIDTH)) u_cps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .new_a_x   (rsp.new_a_x),
    .new_a_y   (rsp.new_a_y),
    .new_b_x   (rsp.new_b_x),
    .new_b_y   (rsp.new_b_y),
    .status    (rsp.status)
);

// File: verif/tb_circle_pair_separation_unit.sv
module tb_circle_pair_separation_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = 32;
    localparam int LATENCY = 106;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [CW-1:0] a_x;
        logic signed [CW-1:0] a_y;
        logic signed [CW-1:0] b_x;
        logic signed [CW-1:0] b_y;
        logic [cps_pkg::RADIUS_W-1:0] a_radius;
        logic [cps_pkg::RADIUS_W-1:0] b_radius;
        logic [cps_pkg::MASS_W-1:0] a_mass;
        logic [cps_pkg::MASS_W-1:0] b_mass;
    } pair_t;

    typedef struct packed {
        logic signed [CW-1:0] new_a_x;
        logic signed [CW-1:0] new_a_y;
        logic signed [CW-1:0] new_b_x;
        logic signed [CW-1:0] new_b_y;
        cps_pkg::status_t status;
    } moved_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    cps_in_if #(CW) req ();
    cps_out_if #(CW) rsp ();

    pair_t pending_pairs[$];
    moved_t expected_moves[$];
    int errors = 0;
    longint cycles = 0;
    bit hold_sender = 1'b0;
    bit in_taken = 1'b0;
    int send_gap = 0;
    int recv_gap = 0;

    circle_pair_separation_unit #(.COORD_WIDTH(CW)) uut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source)
    );

    always #2 clk = ~clk;

    function automatic logic signed [CW-1:0] clamp_coord(logic signed [127:0] v);
        logic signed [127:0] top;
        logic signed [127:0] bot;
        top = (128'sd1 <<< (CW - 1)) - 1;
        bot = -top - 1;
        if (v > top) return top[CW-1:0];
        if (v < bot) return bot[CW-1:0];
        return v[CW-1:0];
    endfunction

    function automatic logic [63:0] floor_root(logic [127:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if ({64'd0, c} * {64'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic moved_t separate(pair_t p);
        moved_t m;
        logic signed [127:0] dx, dy, ux, uy, rr, mag, total, sa, sb, den;
        logic signed [127:0] qax, qay, qbx, qby;
        logic neg, px, py;
        m.new_a_x = p.a_x;
        m.new_a_y = p.a_y;
        m.new_b_x = p.b_x;
        m.new_b_y = p.b_y;
        m.status = cps_pkg::STATUS_MOVED;
        dx = 128'(p.a_x) - 128'(p.b_x);
        dy = 128'(p.a_y) - 128'(p.b_y);
        total = 128'(p.a_mass) + 128'(p.b_mass);
        if (dx == 0 && dy == 0) begin
            m.status = cps_pkg::STATUS_COINCIDENT;
        end else if (total == 0) begin
            m.status = cps_pkg::STATUS_NO_MASS;
        end else begin
            ux = dx < 0 ? -dx : dx;
            uy = dy < 0 ? -dy : dy;
            den = 128'(floor_root(ux * ux + uy * uy));
            rr = 128'(p.a_radius) + 128'(p.b_radius) - den;
            neg = rr < 0;
            mag = neg ? -rr : rr;
            sa = (mag * 128'(p.b_mass)) / total;
            sb = (mag * 128'(p.a_mass)) / total;
            den = den * 2;
            px = (dx > 0) != neg;
            py = (dy > 0) != neg;
            qax = (ux * sa) / den;
            qay = (uy * sa) / den;
            qbx = (ux * sb) / den;
            qby = (uy * sb) / den;
            m.new_a_x = clamp_coord(px ? 128'(p.a_x) + qax : 128'(p.a_x) - qax);
            m.new_a_y = clamp_coord(py ? 128'(p.a_y) + qay : 128'(p.a_y) - qay);
            m.new_b_x = clamp_coord(px ? 128'(p.b_x) - qbx : 128'(p.b_x) + qbx);
            m.new_b_y = clamp_coord(py ? 128'(p.b_y) - qby : 128'(p.b_y) + qby);
        end
        return m;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] any_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 40 << 16)) - (20 << 16));
            3: return $urandom_range(0, 3) - 2;
            default: return $urandom;
        endcase
    endfunction

    function automatic pair_t random_pair();
        pair_t p;
        if ($urandom_range(0, 3) != 0) begin
            // realistic scene: nearby circles with moderate sizes
            p.a_x = 32'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
            p.a_y = 32'(int'($urandom_range(0, 200 << 16)) - (100 << 16));
            p.b_x = p.a_x + 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
            p.b_y = p.a_y + 32'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
            p.a_radius = 31'($urandom_range(0, 8 << 16));
            p.b_radius = 31'($urandom_range(0, 8 << 16));
            p.a_mass = 31'($urandom_range(0, 16 << 16));
            p.b_mass = 31'($urandom_range(0, 16 << 16));
        end else begin
            p.a_x = any_word();
            p.a_y = any_word();
            p.b_x = any_word();
            p.b_y = any_word();
            p.a_radius = 31'(any_word());
            p.b_radius = 31'(any_word());
            p.a_mass = 31'(any_word());
            p.b_mass = 31'(any_word());
        end
        if ($urandom_range(0, 29) == 0) p.b_x = p.a_x;
        if ($urandom_range(0, 29) == 0) begin
            p.b_x = p.a_x;
            p.b_y = p.a_y;
        end
        if ($urandom_range(0, 19) == 0) begin
            p.a_mass = '0;
            p.b_mass = '0;
        end
        return p;
    endfunction

    function automatic pair_t make_pair(logic [31:0] ax, logic [31:0] ay, logic [31:0] bx,
                                        logic [31:0] by, logic [31:0] ra, logic [31:0] rb,
                                        logic [31:0] ma, logic [31:0] mb);
        pair_t p;
        p.a_x = ax;
        p.a_y = ay;
        p.b_x = bx;
        p.b_y = by;
        p.a_radius = ra[30:0];
        p.b_radius = rb[30:0];
        p.a_mass = ma[30:0];
        p.b_mass = mb[30:0];
        return p;
    endfunction

    // driver: launch beats at the falling edge
    always @(negedge clk) begin
        if (rst_n) begin
            if (in_taken) begin
                in_taken = 1'b0;
                void'(pending_pairs.pop_front());
                send_gap = pick_gap();
            end
            if (send_gap > 0) send_gap--;
            if (pending_pairs.size() > 0 && send_gap == 0 && !hold_sender) begin
                req.valid <= 1'b1;
                {req.a_x, req.a_y, req.b_x, req.b_y, req.a_radius, req.b_radius,
                 req.a_mass, req.b_mass} <= pending_pairs[0];
            end else begin
                req.valid <= 1'b0;
            end
            if (recv_gap > 0) begin
                recv_gap--;
                rsp.ready <= 1'b0;
            end else begin
                rsp.ready <= 1'b1;
                recv_gap = pick_gap();
            end
        end
    end

    // monitor: sample beats at the rising edge
    always @(posedge clk) begin
        moved_t want;
        moved_t got;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout at %0t", $time);
            $display("tb_circle_pair_separation_unit: done, errors");
            $finish;
        end
        if (rst_n && req.valid && req.ready) begin
            expected_moves.push_back(separate({req.a_x, req.a_y, req.b_x, req.b_y,
                req.a_radius, req.b_radius, req.a_mass, req.b_mass}));
            in_taken = 1'b1;
        end
        if (rst_n && rsp.valid && rsp.ready) begin
            got = {rsp.new_a_x, rsp.new_a_y, rsp.new_b_x, rsp.new_b_y,
                   cps_pkg::status_t'(rsp.status)};
            if (expected_moves.size() == 0) begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
            end else begin
                want = expected_moves.pop_front();
                if (got.new_a_x !== want.new_a_x || got.new_a_y !== want.new_a_y ||
                    got.new_b_x !== want.new_b_x || got.new_b_y !== want.new_b_y ||
                    got.status !== want.status) begin
                    $display("%0t: expected a=(%h,%h) b=(%h,%h) st=%0d", $time,
                             want.new_a_x, want.new_a_y, want.new_b_x, want.new_b_y,
                             want.status);
                    $display("%0t: actual   a=(%h,%h) b=(%h,%h) st=%0d", $time,
                             got.new_a_x, got.new_a_y, got.new_b_x, got.new_b_y,
                             got.status);
                    errors++;
                end
            end
        end
    end

    initial begin
        req.valid = 1'b0;
        {req.a_x, req.a_y, req.b_x, req.b_y} = '0;
        {req.a_radius, req.b_radius, req.a_mass, req.b_mass} = '0;
        rsp.ready = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // overlapping, apart, coincident, zero mass, extremes, one-sided mass
        pending_pairs.push_back(make_pair(0, 0, 32'h0001_0000, 0, 32'h0001_0000,
                                          32'h0001_0000, 32'h0001_0000, 32'h0001_0000));
        pending_pairs.push_back(make_pair(0, 0, 32'h000a_0000, 32'h000a_0000, 32'h0001_0000,
                                          32'h0001_0000, 32'h0002_0000, 32'h0001_0000));
        pending_pairs.push_back(make_pair(32'h0005_0000, 32'h0007_0000, 32'h0005_0000,
                                          32'h0007_0000, 32'h0001_0000, 1, 1, 1));
        pending_pairs.push_back(make_pair(1, 2, 3, 4, 32'h0001_0000, 32'h0001_0000, 0, 0));
        pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
        pending_pairs.push_back(make_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                          32'h8000_0000, '1, '1, '1, '1));
        pending_pairs.push_back(make_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                          32'h7fff_ffff, '1, '1, '1, 0));
        pending_pairs.push_back(make_pair(32'h7fff_fff0, 0, 32'h7fff_ffe0, 0, '1, '1, 0,
                                          '1));
        pending_pairs.push_back(make_pair(32'h8000_0010, 5, 32'h8000_0020, 5, '1, '1, '1,
                                          0));
        pending_pairs.push_back(make_pair(0, 32'h8000_0000, 0, 32'h7fff_ffff, 0, 0, 1, 1));
        pending_pairs.push_back(make_pair(1, 0, 0, 0, 0, 0, 1, 0));
        pending_pairs.push_back(make_pair(0, 1, 0, 0, '1, 0, 0, 1));
        pending_pairs.push_back(make_pair(32'hffff_ffff, 32'hffff_ffff, 0, 0, 0, '1, 1, 1));
        pending_pairs.push_back(make_pair(32'h0003_0000, 32'h0004_0000, 0, 0, 32'h0005_0000,
                                          0, 32'h0001_0000, 32'h0003_0000));
        pending_pairs.push_back(make_pair(32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
                                          32'h5555_5555, 31'h5555_5555, 31'h2aaa_aaaa,
                                          31'h2aaa_aaaa, 31'h5555_5555));
        wait (pending_pairs.size() == 0 && expected_moves.size() == 0);

        // hold the sender until the pipeline drains
        for (int i = 0; i < 60; i++) pending_pairs.push_back(random_pair());
        wait (pending_pairs.size() == 0);
        @(negedge clk);
        hold_sender = 1'b1;
        wait (expected_moves.size() == 0);
        @(negedge clk);
        hold_sender = 1'b0;

        for (int i = 0; i < 375; i++) pending_pairs.push_back(random_pair());
        wait (pending_pairs.size() == 0);
        wait (expected_moves.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0)
            $display("tb_circle_pair_separation_unit: done, clean");
        else
            $display("tb_circle_pair_separation_unit: done, errors");
        $finish;
    end
endmodule

// File: filelist.f
hdl/cps_pkg.sv
hdl/cps_if.sv
hdl/cps_front.sv
hdl/cps_queue.sv
hdl/cps_back.sv
hdl/circle_pair_separation_unit.sv
hdl/cps_checker.sv
verif/tb_circle_pair_separation_unit.sv
